// ----- rtl/ffr_pkg.sv -----
// shared types and constants for the frame fragment reassembler
// used by ffr_front, ffr_back and frame_fragment_reassembler_top
package ffr_pkg;

    localparam int SLOTS_DEF      = 4;
    localparam int FRAG_BYTES_DEF = 1024;
    localparam int MAX_FRAGS_DEF  = 256;
    localparam int MAX_FRAG_LEN   = 1024;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_IDLE    = 2'd3;

    localparam logic [2:0] K_WRITE    = 3'd0;
    localparam logic [2:0] K_DROP     = 3'd1;
    localparam logic [2:0] K_COMPLETE = 3'd2;
    localparam logic [2:0] K_HANDOUT  = 3'd3;
    localparam logic [2:0] K_NONE     = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] ts_sec;
        logic [19:0] ts_usec;
        logic [7:0]  frag_index;
        logic [8:0]  frag_total;
        logic [18:0] frame_len;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [7:0]  data_byte;
        logic [1:0]  release_index;
        logic        first;
        logic        last;
        logic [9:0]  offset;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  slot;
        logic [17:0] byte_addr;
        logic [7:0]  write_data;
        logic [18:0] frame_len;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] ts_sec;
        logic [19:0] ts_usec;
    } t_result;

endpackage

// ----- rtl/ffr_front.sv -----
// front end: accepts items, tracks byte position within a fragment
// and tags first and last bytes; depends on ffr_pkg
module ffr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  ffr_pkg::t_item  i_item,
    input  logic [10:0]     i_frag_len,
    output logic            o_valid,
    output ffr_pkg::t_item  o_item,
    input  logic            i_ready
);
    import ffr_pkg::*;

    logic [9:0]  r_offset;
    logic [10:0] flen;
    logic [9:0]  off;
    logic        take;
    logic        r_valid;
    t_item       r_item;
    t_item       n_item;

    always_comb begin
        flen = i_frag_len;
        if (flen == 11'd0) flen = 11'd1;
        if (flen > 11'(MAX_FRAG_LEN)) flen = 11'(MAX_FRAG_LEN);
        off = ({1'b0, r_offset} >= flen) ? 10'd0 : r_offset;
        n_item        = i_item;
        n_item.offset = off;
        n_item.first  = (off == 10'd0);
        n_item.last   = ({1'b0, off} + 11'd1 >= flen);
    end

    assign o_full  = r_valid && !i_ready;
    assign take    = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_offset <= '0;
        end else begin
            if (take) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            if (take && i_item.op == OP_BYTE) begin
                r_offset <= ({1'b0, off} + 11'd1 >= flen) ? 10'd0 : off + 10'd1;
            end
        end
        if (take) begin
            r_item <= n_item;
        end
    end
endmodule

// ----- rtl/ffr_back.sv -----
// back end: slot table, completion queue and result queue
// depends on ffr_pkg
module ffr_back #(
    parameter int SLOTS      = ffr_pkg::SLOTS_DEF,
    parameter int FRAG_BYTES = ffr_pkg::FRAG_BYTES_DEF,
    parameter int MAX_FRAGS  = ffr_pkg::MAX_FRAGS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ffr_pkg::t_item    i_item,
    output logic              o_ready,
    output logic              o_empty,
    output ffr_pkg::t_result  o_res,
    input  logic              i_pop
);
    import ffr_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0] r_in_use, r_cons;
    logic [31:0] r_sec  [SLOTS];
    logic [19:0] r_usec [SLOTS];
    logic [8:0]  r_tot  [SLOTS];
    logic [8:0]  r_cnt  [SLOTS];
    logic [18:0] r_len  [SLOTS];
    logic [15:0] r_wide [SLOTS];
    logic [15:0] r_high [SLOTS];
    logic [SW-1:0] r_dq [SLOTS];
    logic [SW-1:0] r_head;
    logic [CW-1:0] r_dcnt;
    logic [SW-1:0] r_cur;
    logic          r_drop;

    // result register: one entry, a completion result waits in r_pend
    logic [1:0] r_qn;
    t_result    r_q0;
    logic       r_phase;
    t_result    r_pend;

    logic          hit, freef;
    logic [SW-1:0] hit_s, free_s, s_sel, s_cur, tail;
    logic          drop_now, alloc;
    logic [8:0]    cnt_new;
    t_result       res0;
    logic          do_item;

    function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [SW+CW:0] t;
        t = (SW+CW+1)'(a) + (SW+CW+1)'(b);
        if (t >= (SW+CW+1)'(SLOTS)) t = t - (SW+CW+1)'(SLOTS);
        return t[SW-1:0];
    endfunction

    function automatic t_result meta(input logic [2:0] k, input logic [SW-1:0] s,
                                     input logic [31:0] sec, input logic [19:0] usec,
                                     input logic [18:0] ln, input logic [15:0] w,
                                     input logic [15:0] h);
        t_result r;
        r = '0;
        r.kind = k; r.slot = 2'(s); r.ts_sec = sec; r.ts_usec = usec;
        r.frame_len = ln; r.width = w; r.height = h;
        return r;
    endfunction

    always_comb begin
        hit = 1'b0; hit_s = '0; freef = 1'b0; free_s = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_cons[i] && r_in_use[i] && r_sec[i] == i_item.ts_sec
                && r_usec[i] == i_item.ts_usec) begin
                hit = 1'b1; hit_s = SW'(i);
            end
            if (!r_cons[i] && !r_in_use[i]) begin
                freef = 1'b1; free_s = SW'(i);
            end
        end
    end

    // while r_phase is set, the completion result waits in r_pend and no item is taken
    assign o_ready = !r_phase && (r_qn == 2'd0 || (r_qn == 2'd1 && i_pop));
    assign do_item = i_valid && o_ready;
    assign o_empty = (r_qn == 2'd0);
    assign o_res   = r_q0;
    assign tail    = wrap_add(r_head, r_dcnt);

    always_comb begin
        drop_now = r_drop; s_sel = r_cur; alloc = 1'b0;
        if (i_item.first) begin
            drop_now = 1'b0;
            if (32'(i_item.frag_index) >= 32'(MAX_FRAGS)) drop_now = 1'b1;
            else if (hit) s_sel = hit_s;
            else if (freef) begin s_sel = free_s; alloc = 1'b1; end
            else if (r_dcnt != '0) begin s_sel = r_dq[r_head]; alloc = 1'b1; end
            else drop_now = 1'b1;
        end
        s_cur = s_sel;
        cnt_new = (alloc ? 9'd0 : r_cnt[s_cur]) + 9'd1;
        res0 = '0;
        if (drop_now) res0.kind = K_DROP;
        else begin
            res0.kind = K_WRITE;
            res0.slot = 2'(s_cur);
            res0.byte_addr = 18'(32'(i_item.frag_index) * 32'(FRAG_BYTES)
                                 + 32'(i_item.offset));
            res0.write_data = i_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0; r_cons <= '0; r_head <= '0; r_dcnt <= '0;
            r_cur <= '0; r_drop <= 1'b0; r_qn <= '0; r_phase <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                r_qn <= r_qn - 2'd1;
            end
            if (r_phase && (r_qn == 2'd0 || (r_qn == 2'd1 && i_pop))) begin
                r_phase <= 1'b0;
                r_q0 <= r_pend;
                r_qn <= 2'd1;
            end
            if (do_item) begin
                case (i_item.op)
                    OP_POP: begin
                        r_qn <= 2'd1;
                        if (r_dcnt != '0) begin
                            r_q0 <= meta(K_HANDOUT, r_dq[r_head], r_sec[r_dq[r_head]],
                                r_usec[r_dq[r_head]], r_len[r_dq[r_head]],
                                r_wide[r_dq[r_head]], r_high[r_dq[r_head]]);
                            r_head <= wrap_add(r_head, CW'(1));
                            r_dcnt <= r_dcnt - CW'(1);
                        end else begin
                            r_q0 <= meta(K_NONE, '0, '0, '0, '0, '0, '0);
                        end
                    end
                    OP_RELEASE: begin
                        if (32'(i_item.release_index) < 32'(SLOTS)
                            && r_cons[SW'(i_item.release_index)]) begin
                            r_cons[SW'(i_item.release_index)]   <= 1'b0;
                            r_in_use[SW'(i_item.release_index)] <= 1'b0;
                        end
                    end
                    OP_BYTE: begin
                        r_qn <= 2'd1;
                        r_q0 <= res0;
                        r_drop <= drop_now;
                        r_cur <= s_cur;
                        if (i_item.first && !drop_now && alloc) begin
                            if (!freef) begin
                                r_head <= wrap_add(r_head, CW'(1));
                                r_dcnt <= r_dcnt - CW'(1);
                            end
                            r_sec[s_cur]  <= i_item.ts_sec;
                            r_usec[s_cur] <= i_item.ts_usec;
                            r_len[s_cur]  <= i_item.frame_len;
                            r_wide[s_cur] <= i_item.frame_width;
                            r_high[s_cur] <= i_item.frame_height;
                            r_tot[s_cur]  <= i_item.frag_total;
                            r_cnt[s_cur]  <= 9'd0;
                            r_in_use[s_cur] <= 1'b1;
                            r_cons[s_cur]   <= 1'b0;
                        end
                        if (i_item.last && !drop_now) begin
                            r_cnt[s_cur] <= cnt_new;
                            if (cnt_new == (alloc ? i_item.frag_total : r_tot[s_cur])) begin
                                r_in_use[s_cur] <= 1'b0;
                                r_cons[s_cur]   <= 1'b1;
                                r_phase <= 1'b1;
                                r_pend  <= meta(K_COMPLETE, s_cur,
                                    alloc ? i_item.ts_sec : r_sec[s_cur],
                                    alloc ? i_item.ts_usec : r_usec[s_cur],
                                    alloc ? i_item.frame_len : r_len[s_cur],
                                    alloc ? i_item.frame_width : r_wide[s_cur],
                                    alloc ? i_item.frame_height : r_high[s_cur]);
                                if (32'(r_dcnt) - ((alloc && !freef) ? 32'd1 : 32'd0)
                                    < 32'(SLOTS)) begin
                                    if (alloc && !freef) begin
                                        // reclaimed head leaves, this slot joins: count holds
                                        r_dq[wrap_add(r_head, CW'(r_dcnt))] <= s_cur;
                                        r_dcnt <= r_dcnt;
                                    end else begin
                                        r_dq[tail] <= s_cur;
                                        r_dcnt <= r_dcnt + CW'(1);
                                    end
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- rtl/frame_fragment_reassembler_top.sv -----
// latency: an item is registered in ffr_front, then its result in the result
// register of ffr_back; a frame completion adds a second result from r_pend
// throughput: one item per cycle while results are popped; a byte that
// completes a frame holds later items until its second result is queued
// reset: synchronous, active low; clears slot ownership, queues and offset
// depends on ffr_pkg, ffr_front and ffr_back
module frame_fragment_reassembler_top #(
    parameter int SLOTS      = ffr_pkg::SLOTS_DEF,
    parameter int FRAG_BYTES = ffr_pkg::FRAG_BYTES_DEF,
    parameter int MAX_FRAGS  = ffr_pkg::MAX_FRAGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_ts_sec,
    input  logic [19:0] i_ts_usec,
    input  logic [7:0]  i_frag_index,
    input  logic [8:0]  i_frag_total,
    input  logic [10:0] i_frag_len,
    input  logic [18:0] i_frame_len,
    input  logic [15:0] i_frame_width,
    input  logic [15:0] i_frame_height,
    input  logic [7:0]  i_data_byte,
    input  logic [1:0]  i_release_index,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_slot,
    output logic [17:0] o_byte_addr,
    output logic [7:0]  o_write_data,
    output logic [18:0] o_out_frame_len,
    output logic [15:0] o_out_width,
    output logic [15:0] o_out_height,
    output logic [31:0] o_out_ts_sec,
    output logic [19:0] o_out_ts_usec
);
    import ffr_pkg::*;

    t_item   in_item, q_item;
    t_result res;
    logic    q_valid, q_ready;

    always_comb begin
        in_item = '0;
        in_item.op = i_op;
        in_item.ts_sec = i_ts_sec;
        in_item.ts_usec = i_ts_usec;
        in_item.frag_index = i_frag_index;
        in_item.frag_total = i_frag_total;
        in_item.frame_len = i_frame_len;
        in_item.frame_width = i_frame_width;
        in_item.frame_height = i_frame_height;
        in_item.data_byte = i_data_byte;
        in_item.release_index = i_release_index;
    end

    ffr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(in_item), .i_frag_len(i_frag_len),
        .o_valid(q_valid), .o_item(q_item), .i_ready(q_ready)
    );

    ffr_back #(.SLOTS(SLOTS), .FRAG_BYTES(FRAG_BYTES), .MAX_FRAGS(MAX_FRAGS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_ready(q_ready), .o_empty(empty), .o_res(res), .i_pop(pop)
    );

    assign o_kind          = res.kind;
    assign o_slot          = res.slot;
    assign o_byte_addr     = res.byte_addr;
    assign o_write_data    = res.write_data;
    assign o_out_frame_len = res.frame_len;
    assign o_out_width     = res.width;
    assign o_out_height    = res.height;
    assign o_out_ts_sec    = res.ts_sec;
    assign o_out_ts_usec   = res.ts_usec;
endmodule
